// File: hdl/rmf_pkg.sv
// Shared constants, codes and controller/datapath types of the RGB median filter.
`default_nettype none
package rmf_pkg;
   localparam int MAX_WIDTH_DEF = 1024;
   localparam int RADIUS_DEF    = 4;

   localparam int CH_W      = 8;
   localparam int PIX_W     = 3 * CH_W;
   localparam int IMG_W_W   = 11;
   localparam int IMG_H_W   = 16;
   localparam int OUT_COL_W = 10;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 16;
   localparam int BIT_W     = 3;

   localparam logic [IMG_W_W-1:0] WIDTH_RST  = IMG_W_W'(1024);
   localparam logic [IMG_H_W-1:0] HEIGHT_RST = IMG_H_W'(768);

   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_WIDTH  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_HEIGHT = CSR_IDX_W'(1);

   localparam logic KIND_PIXEL = 1'b0;
   localparam logic KIND_DRAIN = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_LAST,
      ST_INIT,
      ST_COUNT,
      ST_DECIDE,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic             accept;
      logic             load_step;
      logic             sel_init;
      logic             rank;
      logic             count;
      logic             decide;
      logic [BIT_W-1:0] bit_idx;
      logic             out_load;
   } cmd_type;

   typedef struct packed {
      logic emits;
      logic load_last;
      logic rsp_busy;
   } sts_type;
endpackage
`default_nettype wire

// File: hdl/rmf_ctrl.sv
// Controller state machine: window load, radix selection passes and result hand-off.
`default_nettype none
module rmf_ctrl
   import rmf_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire sts_type sts,
   output cmd_type      cmd
);
   state_type        state_ff, state_in;
   logic [BIT_W-1:0] bit_ff, bit_in;
   logic             rank_ff, rank_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         bit_ff   <= '1;
         rank_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         bit_ff   <= bit_in;
         rank_ff  <= rank_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      bit_in   = bit_ff;
      rank_in  = rank_ff;
      unique case (state_ff)
         ST_IDLE: begin
            rank_in = 1'b0;
            if (req_valid && sts.emits) state_in = ST_LOAD;
         end
         ST_LOAD: begin
            if (sts.load_last) state_in = ST_LAST;
         end
         ST_LAST: state_in = ST_INIT;
         ST_INIT: begin
            bit_in   = '1;
            state_in = ST_COUNT;
         end
         ST_COUNT: state_in = ST_DECIDE;
         ST_DECIDE: begin
            if (bit_ff == '0) begin
               if (rank_ff) begin
                  state_in = ST_FINISH;
               end else begin
                  rank_in  = 1'b1;
                  state_in = ST_INIT;
               end
            end else begin
               bit_in   = bit_ff - BIT_W'(1);
               state_in = ST_COUNT;
            end
         end
         ST_FINISH: begin
            if (!sts.rsp_busy) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd         = '0;
      cmd.rank    = rank_ff;
      cmd.bit_idx = bit_ff;
      req_stall   = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall  = 1'b0;
            cmd.accept = req_valid;
         end
         ST_LOAD:   cmd.load_step = 1'b1;
         ST_LAST:   cmd.load_step = 1'b0;
         ST_INIT:   cmd.sel_init  = 1'b1;
         ST_COUNT:  cmd.count     = 1'b1;
         ST_DECIDE: cmd.decide    = 1'b1;
         ST_FINISH: cmd.out_load  = !sts.rsp_busy;
         default:   cmd.out_load  = 1'b0;
      endcase
   end
endmodule
`default_nettype wire

// File: hdl/rmf_datapath.sv
// Datapath: configuration, position counters, line store, window shift line, radix select.
`default_nettype none
module rmf_datapath
   import rmf_pkg::*;
#(
   parameter int MAX_WIDTH = MAX_WIDTH_DEF,
   parameter int RADIUS    = RADIUS_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire cmd_type              cmd,
   output sts_type                   sts,
   input  wire logic                 req_kind,
   input  wire logic [CH_W-1:0]      req_red_in,
   input  wire logic [CH_W-1:0]      req_green_in,
   input  wire logic [CH_W-1:0]      req_blue_in,
   input  wire logic                 csr_write,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CSR_DAT_W-1:0] csr_data,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic [CH_W-1:0]           rsp_red_out,
   output logic [CH_W-1:0]           rsp_green_out,
   output logic [CH_W-1:0]           rsp_blue_out,
   output logic [OUT_COL_W-1:0]      rsp_out_column,
   output logic [IMG_H_W-1:0]        rsp_out_row,
   output logic                      rsp_frame_end
);
   localparam int LS_ROWS = 2 * RADIUS + 2;
   localparam int SPAN    = 2 * RADIUS + 1;
   localparam int WIN_N   = SPAN * SPAN;
   localparam int COL_W   = $clog2(MAX_WIDTH);
   localparam int WW      = $clog2(MAX_WIDTH + 1);
   localparam int EW      = (WW > IMG_W_W) ? WW : IMG_W_W;
   localparam int XW      = WW + 1;
   localparam int RSW     = $clog2(LS_ROWS);
   localparam int SW      = $clog2(LS_ROWS + SPAN);
   localparam int AW      = $clog2(LS_ROWS * MAX_WIDTH);
   localparam int DW      = $clog2(RADIUS * MAX_WIDTH + RADIUS + 1);
   localparam int DYW     = $clog2(SPAN);
   localparam int CW      = $clog2(WIN_N + 1);
   localparam int RW      = IMG_H_W + 1;

   logic [IMG_W_W-1:0]   img_w_ff, img_w_in;
   logic [IMG_H_W-1:0]   img_h_ff, img_h_in;
   logic [COL_W-1:0]     in_col_ff, in_col_in, out_col_ff, out_col_in;
   logic [IMG_H_W-1:0]   in_row_ff, in_row_in, out_row_ff, out_row_in;
   logic [RSW-1:0]       in_rs_ff, in_rs_in, out_rs_ff, out_rs_in;
   logic                 full_ff, full_in;
   logic [DW-1:0]        pcnt_ff, pcnt_in;
   logic [COL_W-1:0]     cur_col_ff;
   logic [IMG_H_W-1:0]   cur_row_ff;
   logic [RSW-1:0]       cur_rs_ff;
   logic                 cur_fe_ff;

   logic [WW-1:0]        w_eff;
   logic [IMG_H_W-1:0]   h_eff;
   logic [DW-1:0]        delay;
   logic                 is_pixel, last_col, last_row, emits, mem_we;
   logic [COL_W-1:0]     base_col;
   logic [IMG_H_W-1:0]   base_row;
   logic [RSW-1:0]       base_rs;

   logic [PIX_W-1:0]     ls_mem [LS_ROWS * MAX_WIDTH];
   logic [AW-1:0]        wr_addr, rd_addr;
   logic [PIX_W-1:0]     rd_data_ff;
   logic                 rd_pend_ff, rd_msk_ff, rd_ok;
   logic [DYW-1:0]       dy_ff, dx_ff;
   logic [SW-1:0]        srow_t;
   logic [RSW-1:0]       srow;
   logic [RW-1:0]        rsum;
   logic [XW-1:0]        csum;

   logic [PIX_W-1:0]     win_ff [WIN_N];
   logic                 msk_ff [WIN_N];
   logic [CW-1:0]        n_ff;
   logic [CH_W-1:0]      pre_ff [3];
   logic [CH_W-1:0]      lo_ff  [3];
   logic [CW-1:0]        kk_ff  [3];
   logic [CW-1:0]        cnt_ff [3];
   logic [CW-1:0]        cnt_c  [3];
   logic [CH_W-1:0]      hmask;
   logic [CH_W:0]        avg    [3];
   logic                 rsp_valid_ff;

   always_comb begin
      if (img_w_ff == '0) begin
         w_eff = WW'(1);
      end else if (EW'(img_w_ff) > EW'(MAX_WIDTH)) begin
         w_eff = WW'(MAX_WIDTH);
      end else begin
         w_eff = WW'(img_w_ff);
      end
      h_eff = (img_h_ff == '0) ? IMG_H_W'(1) : img_h_ff;
      delay = DW'(RADIUS) * DW'(w_eff)
            + ((WW'(RADIUS) < w_eff - WW'(1)) ? DW'(RADIUS) : DW'(w_eff - WW'(1)));
   end

   always_comb begin
      is_pixel = (req_kind == KIND_PIXEL);
      base_col = (is_pixel && full_ff) ? '0 : out_col_ff;
      base_row = (is_pixel && full_ff) ? '0 : out_row_ff;
      base_rs  = (is_pixel && full_ff) ? '0 : out_rs_ff;
      emits    = is_pixel ? (pcnt_ff >= delay && base_row < h_eff)
                          : (full_ff && base_row < h_eff);
      last_col = (WW'(in_col_ff) + WW'(1) >= w_eff);
      last_row = (RW'(in_row_ff) + RW'(1) >= RW'(h_eff));
      mem_we   = cmd.accept && is_pixel;
      wr_addr  = AW'(in_rs_ff) * AW'(MAX_WIDTH) + AW'(in_col_ff);
   end

   always_comb begin
      img_w_in   = img_w_ff;
      img_h_in   = img_h_ff;
      in_col_in  = in_col_ff;
      in_row_in  = in_row_ff;
      in_rs_in   = in_rs_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      out_rs_in  = out_rs_ff;
      full_in    = full_ff;
      pcnt_in    = pcnt_ff;
      if (cmd.accept) begin
         if (is_pixel) begin
            full_in = 1'b0;
            pcnt_in = (pcnt_ff >= delay) ? pcnt_ff : pcnt_ff + DW'(1);
            if (last_col) begin
               in_col_in = '0;
               in_row_in = in_row_ff + IMG_H_W'(1);
               in_rs_in  = (in_rs_ff == RSW'(LS_ROWS - 1)) ? '0 : in_rs_ff + RSW'(1);
               if (last_row) begin
                  in_row_in = '0;
                  in_rs_in  = '0;
                  full_in   = 1'b1;
                  pcnt_in   = '0;
               end
            end else begin
               in_col_in = in_col_ff + COL_W'(1);
            end
         end
         out_col_in = base_col;
         out_row_in = base_row;
         out_rs_in  = base_rs;
         if (emits) begin
            if (WW'(base_col) + WW'(1) >= w_eff) begin
               out_col_in = '0;
               out_row_in = base_row + IMG_H_W'(1);
               out_rs_in  = (base_rs == RSW'(LS_ROWS - 1)) ? '0 : base_rs + RSW'(1);
            end else begin
               out_col_in = base_col + COL_W'(1);
            end
         end
      end
      if (csr_write) begin
         unique case (csr_index)
            REG_IMAGE_WIDTH:  img_w_in = csr_data[IMG_W_W-1:0];
            REG_IMAGE_HEIGHT: img_h_in = csr_data[IMG_H_W-1:0];
            default:          img_w_in = img_w_ff;
         endcase
         if (csr_index == REG_IMAGE_WIDTH || csr_index == REG_IMAGE_HEIGHT) begin
            in_col_in  = '0;
            in_row_in  = '0;
            in_rs_in   = '0;
            out_col_in = '0;
            out_row_in = '0;
            out_rs_in  = '0;
            full_in    = 1'b0;
            pcnt_in    = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         img_w_ff   <= WIDTH_RST;
         img_h_ff   <= HEIGHT_RST;
         in_col_ff  <= '0;
         in_row_ff  <= '0;
         in_rs_ff   <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
         out_rs_ff  <= '0;
         full_ff    <= 1'b0;
         pcnt_ff    <= '0;
      end else begin
         img_w_ff   <= img_w_in;
         img_h_ff   <= img_h_in;
         in_col_ff  <= in_col_in;
         in_row_ff  <= in_row_in;
         in_rs_ff   <= in_rs_in;
         out_col_ff <= out_col_in;
         out_row_ff <= out_row_in;
         out_rs_ff  <= out_rs_in;
         full_ff    <= full_in;
         pcnt_ff    <= pcnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept && emits) begin
         cur_col_ff <= base_col;
         cur_row_ff <= base_row;
         cur_rs_ff  <= base_rs;
         cur_fe_ff  <= (base_row == h_eff - IMG_H_W'(1))
                    && (WW'(base_col) == w_eff - WW'(1));
      end
   end

   // window addressing, clipped at the image border
   always_comb begin
      srow_t = SW'(cur_rs_ff) + SW'(dy_ff);
      if (srow_t < SW'(RADIUS)) begin
         srow = RSW'(srow_t + SW'(LS_ROWS - RADIUS));
      end else if (srow_t - SW'(RADIUS) >= SW'(LS_ROWS)) begin
         srow = RSW'(srow_t - SW'(RADIUS + LS_ROWS));
      end else begin
         srow = RSW'(srow_t - SW'(RADIUS));
      end
      rsum    = RW'(cur_row_ff) + RW'(dy_ff);
      csum    = XW'(cur_col_ff) + XW'(dx_ff);
      rd_ok   = (rsum >= RW'(RADIUS)) && (rsum < RW'(h_eff) + RW'(RADIUS))
             && (csum >= XW'(RADIUS)) && (csum < XW'(w_eff) + XW'(RADIUS));
      rd_addr = AW'(srow) * AW'(MAX_WIDTH) + AW'(COL_W'(csum - XW'(RADIUS)));
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         ls_mem[wr_addr] <= {req_red_in, req_green_in, req_blue_in};
      end
      rd_data_ff <= ls_mem[rd_addr];
      rd_msk_ff  <= rd_ok;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_pend_ff <= 1'b0;
         dy_ff      <= '0;
         dx_ff      <= '0;
      end else begin
         rd_pend_ff <= cmd.load_step;
         if (cmd.accept) begin
            dy_ff <= '0;
            dx_ff <= '0;
         end else if (cmd.load_step) begin
            if (dx_ff == DYW'(SPAN - 1)) begin
               dx_ff <= '0;
               dy_ff <= dy_ff + DYW'(1);
            end else begin
               dx_ff <= dx_ff + DYW'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rd_pend_ff) begin
         win_ff[0] <= rd_data_ff;
         msk_ff[0] <= rd_msk_ff;
         for (int i = 1; i < WIN_N; i++) begin
            win_ff[i] <= win_ff[i-1];
            msk_ff[i] <= msk_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         n_ff <= '0;
      end else if (rd_pend_ff && rd_msk_ff) begin
         n_ff <= n_ff + CW'(1);
      end
   end

   // radix select: count entries below the candidate at the current bit
   always_comb begin
      hmask = CH_W'(8'hFF << (4'(cmd.bit_idx) + 4'd1));
      for (int c = 0; c < 3; c++) begin
         cnt_c[c] = '0;
         for (int i = 0; i < WIN_N; i++) begin
            cnt_c[c] = cnt_c[c] + CW'(msk_ff[i]
               && (((win_ff[i][CH_W*(2-c) +: CH_W] ^ pre_ff[c]) & hmask) == '0)
               && !win_ff[i][CH_W*(2-c) + 32'(cmd.bit_idx)]);
         end
         avg[c] = ({1'b0, lo_ff[c]} + {1'b0, pre_ff[c]}) >> 1;
      end
   end

   always_ff @(posedge clock) begin
      for (int c = 0; c < 3; c++) begin
         if (cmd.sel_init) begin
            if (cmd.rank) lo_ff[c] <= pre_ff[c];
            pre_ff[c] <= '0;
            kk_ff[c]  <= cmd.rank ? (n_ff >> 1) : ((n_ff - CW'(1)) >> 1);
         end else if (cmd.decide && kk_ff[c] >= cnt_ff[c]) begin
            pre_ff[c][cmd.bit_idx] <= 1'b1;
            kk_ff[c] <= kk_ff[c] - cnt_ff[c];
         end
         if (cmd.count) cnt_ff[c] <= cnt_c[c];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_red_out    <= avg[0][CH_W-1:0];
         rsp_green_out  <= avg[1][CH_W-1:0];
         rsp_blue_out   <= avg[2][CH_W-1:0];
         rsp_out_column <= OUT_COL_W'(cur_col_ff);
         rsp_out_row    <= cur_row_ff;
         rsp_frame_end  <= cur_fe_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign sts.emits     = emits;
   assign sts.load_last = (dy_ff == DYW'(SPAN - 1)) && (dx_ff == DYW'(SPAN - 1));
   assign sts.rsp_busy  = rsp_valid_ff && rsp_stall;
endmodule
`default_nettype wire

// File: hdl/rgb_median_filter_9x9_unit.sv
// Top level of the streaming per-channel RGB median filter with clipped window.
//  channel | handshake          | payload
//  req     | req_valid/stall    | kind, red_in, green_in, blue_in
//  rsp     | rsp_valid/stall    | red/green/blue_out, out_column, out_row, frame_end
//  csr     | csr_valid/ready    | csr_index, csr_data
// An item that yields no result is taken without a stall. One that yields a
// result stalls the request side: one line store read per window entry,
// then 2 ranks x 8 bit passes, each a count state and a decide state.
// Reset clears counters and control; the line store is not cleared.
// A stalled result is held while the next item is accepted.
`default_nettype none
module rgb_median_filter_9x9_unit
   import rmf_pkg::*;
#(
   parameter int MAX_WIDTH = MAX_WIDTH_DEF,
   parameter int RADIUS    = RADIUS_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic                 req_kind,
   input  wire logic [CH_W-1:0]      req_red_in,
   input  wire logic [CH_W-1:0]      req_green_in,
   input  wire logic [CH_W-1:0]      req_blue_in,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic [CH_W-1:0]           rsp_red_out,
   output logic [CH_W-1:0]           rsp_green_out,
   output logic [CH_W-1:0]           rsp_blue_out,
   output logic [OUT_COL_W-1:0]      rsp_out_column,
   output logic [IMG_H_W-1:0]        rsp_out_row,
   output logic                      rsp_frame_end,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CSR_DAT_W-1:0] csr_data
);
   cmd_type cmd;
   sts_type sts;

   assign csr_ready = 1'b1;

   rmf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   rmf_datapath #(
      .MAX_WIDTH (MAX_WIDTH),
      .RADIUS    (RADIUS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .req_kind       (req_kind),
      .req_red_in     (req_red_in),
      .req_green_in   (req_green_in),
      .req_blue_in    (req_blue_in),
      .csr_write      (csr_valid && csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_red_out    (rsp_red_out),
      .rsp_green_out  (rsp_green_out),
      .rsp_blue_out   (rsp_blue_out),
      .rsp_out_column (rsp_out_column),
      .rsp_out_row    (rsp_out_row),
      .rsp_frame_end  (rsp_frame_end)
   );
endmodule
`default_nettype wire
